>>> rtl/srd_pkg.sv
// shared constants and types of the stick radial deadzone unit
`default_nettype none
package srd_pkg;
  localparam int RAW_W     = 16;
  localparam int OUT_W     = 17;
  localparam int DZ_W      = 15;
  localparam int AX_W      = 31;          // raw magnitude times 32767 or 32768
  localparam int SQ_W      = 62;          // sum of squares
  localparam int M_W       = 31;          // integer square root
  localparam int DEN_W     = M_W + DZ_W;  // magnitude times (32767 - d)
  localparam int NUM_W     = AX_W + M_W;  // axis times (magnitude - deadzone)
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 17;
  localparam int IDX_W     = 1;

  localparam logic [IDX_W-1:0] REG_LEFT_DZ  = 1'd0;
  localparam logic [IDX_W-1:0] REG_RIGHT_DZ = 1'd1;

  localparam logic [DZ_W-1:0] LEFT_DZ_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0] RIGHT_DZ_RESET = 15'd8689;
  localparam logic [DZ_W-1:0] DZ_MAX         = 15'd32766;
  localparam logic [DZ_W-1:0] FULL_SCALE     = 15'd32767;

  localparam logic [OUT_W:0] POS_SAT = 18'd65535;
  localparam logic [OUT_W:0] NEG_SAT = 18'd65536;

  // fields that ride along the pipeline beside the arithmetic
  typedef struct packed {
    logic            neg_x;
    logic            neg_y;
    logic            dz;
    logic [DZ_W-1:0] d;
    logic [AX_W-1:0] ax;
    logic [AX_W-1:0] ay;
  } ctl_t;
endpackage
`default_nettype wire

>>> rtl/srd_if.sv
// sample and result channels of the stick radial deadzone unit
`default_nettype none
interface srd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [srd_pkg::RAW_W-1:0]    raw_x;
  logic signed [srd_pkg::RAW_W-1:0]    raw_y;
  modport source (output valid, kind, raw_x, raw_y, input ready);
  modport sink   (input valid, kind, raw_x, raw_y, output ready);
endinterface

interface srd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [srd_pkg::OUT_W-1:0]    out_x;
  logic signed [srd_pkg::OUT_W-1:0]    out_y;
  logic                                in_deadzone;
  modport source (output valid, out_x, out_y, in_deadzone, input ready);
  modport sink   (input valid, out_x, out_y, in_deadzone, output ready);
endinterface
`default_nettype wire

>>> rtl/stick_radial_deadzone_unit.sv
// top level of the stick radial deadzone unit
`default_nettype none
// Scaled radial deadzone for one thumbstick sample per beat. A sample beat
// (kind, raw_x, raw_y) is taken in every cycle while the result side keeps
// up. The pipeline holds the square root, one bit per stage over 31 stages,
// and the rescale division, one quotient bit per stage over 17 stages. The
// whole pipeline freezes while a result beat waits, so nothing is dropped
// or repeated.
// Deadzone registers are written through cfg_we / cfg_index / cfg_data and
// should only change while the pipeline is empty. Outputs are signed Q2.15,
// truncated toward zero, saturated to the 17-bit range.
module stick_radial_deadzone_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [srd_pkg::IDX_W-1:0]     cfg_index,
  input  wire [srd_pkg::DZ_W-1:0]      cfg_data,
  srd_in_if.sink                       sample,
  srd_out_if.source                    result
);
  import srd_pkg::*;

  // configuration registers
  logic [DZ_W-1:0] left_dz;
  logic [DZ_W-1:0] right_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RESET;
      right_dz <= RIGHT_DZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_DZ:  left_dz  <= cfg_data;
        REG_RIGHT_DZ: right_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being emptied
  logic adv;
  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;

  // stage a: scale axes, clamp deadzone
  logic            a_v;
  ctl_t            a_c;
  logic [RAW_W-1:0] abs_x, abs_y;
  logic [DZ_W-1:0]  d_sel;

  always_comb begin
    abs_x = sample.raw_x[RAW_W-1] ? (~sample.raw_x + 16'd1) : sample.raw_x;
    abs_y = sample.raw_y[RAW_W-1] ? (~sample.raw_y + 16'd1) : sample.raw_y;
    d_sel = sample.kind ? right_dz : left_dz;
    if (d_sel > DZ_MAX) d_sel = DZ_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= sample.valid;
    if (adv) begin
      a_c.neg_x <= sample.raw_x[RAW_W-1];
      a_c.neg_y <= sample.raw_y[RAW_W-1];
      a_c.dz    <= 1'b0;
      a_c.d     <= d_sel;
      // negative side scales by 32767, positive by 32768
      a_c.ax <= sample.raw_x[RAW_W-1] ? ({abs_x, 15'd0} - AX_W'(abs_x)) : {abs_x, 15'd0};
      a_c.ay <= sample.raw_y[RAW_W-1] ? ({abs_y, 15'd0} - AX_W'(abs_y)) : {abs_y, 15'd0};
    end
  end

  // stage b: squares
  logic              b_v;
  ctl_t              b_c;
  logic [SQ_W-1:0]   b_sqx, b_sqy;
  logic [2*DZ_W-1:0] b_dd;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
    if (adv) begin
      b_c   <= a_c;
      b_sqx <= SQ_W'(a_c.ax) * SQ_W'(a_c.ax);
      b_sqy <= SQ_W'(a_c.ay) * SQ_W'(a_c.ay);
      b_dd  <= (2*DZ_W)'(a_c.d) * (2*DZ_W)'(a_c.d);
    end
  end

  // stage c: sum of squares and the exact deadzone test against (d * 32768)^2
  logic            c_v;
  ctl_t            c_c;
  ctl_t            c_next;
  logic [SQ_W-1:0] c_sum;
  logic [SQ_W-1:0] sum_b;

  assign sum_b = b_sqx + b_sqy;

  always_comb begin
    c_next    = b_c;
    c_next.dz = sum_b < {2'b00, b_dd, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= b_v;
    if (adv) begin
      c_c   <= c_next;
      c_sum <= sum_b;
    end
  end

  // square root: one result bit per stage
  logic            sq_v   [SQ_STEPS+1];
  ctl_t            sq_c   [SQ_STEPS+1];
  logic [SQ_W-1:0] sq_rem [SQ_STEPS+1];
  logic [SQ_W-1:0] sq_r   [SQ_STEPS+1];

  assign sq_v[0]   = c_v;
  assign sq_c[0]   = c_c;
  assign sq_rem[0] = c_sum;
  assign sq_r[0]   = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2*(SQ_STEPS-1-k));
    logic [SQ_W-1:0] trial;
    assign trial = sq_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
      if (adv) begin
        sq_c[k+1] <= sq_c[k];
        if (sq_rem[k] >= trial) begin
          sq_rem[k+1] <= sq_rem[k] - trial;
          sq_r[k+1]   <= (sq_r[k] >> 1) + BIT;
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_r[k+1]   <= sq_r[k] >> 1;
        end
      end
    end
  end

  // stage e: magnitude less deadzone, and the divisor
  logic             e_v;
  ctl_t             e_c;
  logic             e_zero;
  logic [M_W-1:0]   e_mmd;
  logic [DEN_W-1:0] e_den;
  logic [M_W-1:0]   mag;

  assign mag = sq_r[SQ_STEPS][M_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= sq_v[SQ_STEPS];
    if (adv) begin
      e_c    <= sq_c[SQ_STEPS];
      e_zero <= mag == '0;
      // only meaningful outside the deadzone, where magnitude >= d * 32768
      e_mmd  <= mag - {1'b0, sq_c[SQ_STEPS].d, 15'd0};
      e_den  <= DEN_W'(mag) * DEN_W'(FULL_SCALE - sq_c[SQ_STEPS].d);
    end
  end

  // stage f: dividends
  logic             f_v;
  ctl_t             f_c;
  logic             f_zero;
  logic [DEN_W-1:0] f_den;
  logic [NUM_W-1:0] f_numx, f_numy;

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
    if (adv) begin
      f_c    <= e_c;
      f_zero <= e_zero;
      f_den  <= e_den;
      f_numx <= NUM_W'(e_c.ax) * NUM_W'(e_mmd);
      f_numy <= NUM_W'(e_c.ay) * NUM_W'(e_mmd);
    end
  end

  // division: overflow check, then one quotient bit per stage
  localparam int REM_W = NUM_W + 1;

  logic             dv_v    [DIV_STEPS+1];
  ctl_t             dv_c    [DIV_STEPS+1];
  logic             dv_zero [DIV_STEPS+1];
  logic             dv_ovx  [DIV_STEPS+1];
  logic             dv_ovy  [DIV_STEPS+1];
  logic [DEN_W-1:0] dv_den  [DIV_STEPS+1];
  logic [REM_W-1:0] dv_rx   [DIV_STEPS+1];
  logic [REM_W-1:0] dv_ry   [DIV_STEPS+1];
  logic [OUT_W-1:0] dv_qx   [DIV_STEPS+1];
  logic [OUT_W-1:0] dv_qy   [DIV_STEPS+1];

  logic [REM_W+1:0] den_top;
  assign den_top = (REM_W+2)'(f_den) << DIV_STEPS;

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= f_v;
    if (adv) begin
      dv_c[0]    <= f_c;
      dv_zero[0] <= f_zero;
      dv_den[0]  <= f_den;
      // quotient of 2^17 or more saturates either way
      dv_ovx[0]  <= (REM_W+2)'(f_numx) >= den_top;
      dv_ovy[0]  <= (REM_W+2)'(f_numy) >= den_top;
      dv_rx[0]   <= REM_W'(f_numx);
      dv_ry[0]   <= REM_W'(f_numy);
      dv_qx[0]   <= '0;
      dv_qy[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [REM_W+SH:0] dsh;
    assign dsh = (REM_W+SH+1)'(dv_den[j]) << SH;
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (adv) dv_v[j+1] <= dv_v[j];
      if (adv) begin
        dv_c[j+1]    <= dv_c[j];
        dv_zero[j+1] <= dv_zero[j];
        dv_ovx[j+1]  <= dv_ovx[j];
        dv_ovy[j+1]  <= dv_ovy[j];
        dv_den[j+1]  <= dv_den[j];
        if ((REM_W+SH+1)'(dv_rx[j]) >= dsh) begin
          dv_rx[j+1] <= dv_rx[j] - dsh[REM_W-1:0];
          dv_qx[j+1] <= {dv_qx[j][OUT_W-2:0], 1'b1};
        end else begin
          dv_rx[j+1] <= dv_rx[j];
          dv_qx[j+1] <= {dv_qx[j][OUT_W-2:0], 1'b0};
        end
        if ((REM_W+SH+1)'(dv_ry[j]) >= dsh) begin
          dv_ry[j+1] <= dv_ry[j] - dsh[REM_W-1:0];
          dv_qy[j+1] <= {dv_qy[j][OUT_W-2:0], 1'b1};
        end else begin
          dv_ry[j+1] <= dv_ry[j];
          dv_qy[j+1] <= {dv_qy[j][OUT_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register: saturate, apply sign, zero inside the deadzone
  ctl_t             fc;
  logic [OUT_W:0]   qx, qy;
  logic [OUT_W-1:0] enc_x, enc_y;

  assign fc = dv_c[DIV_STEPS];

  always_comb begin
    qx = dv_ovx[DIV_STEPS] ? '1 : {1'b0, dv_qx[DIV_STEPS]};
    qy = dv_ovy[DIV_STEPS] ? '1 : {1'b0, dv_qy[DIV_STEPS]};
    if (fc.neg_x) begin
      if (qx > NEG_SAT) qx = NEG_SAT;
    end else if (qx > POS_SAT) begin
      qx = POS_SAT;
    end
    if (fc.neg_y) begin
      if (qy > NEG_SAT) qy = NEG_SAT;
    end else if (qy > POS_SAT) begin
      qy = POS_SAT;
    end
    enc_x = fc.neg_x ? OUT_W'(~qx + 18'd1) : qx[OUT_W-1:0];
    enc_y = fc.neg_y ? OUT_W'(~qy + 18'd1) : qy[OUT_W-1:0];
    if (fc.dz || dv_zero[DIV_STEPS]) begin
      enc_x = '0;
      enc_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (adv) result.valid <= dv_v[DIV_STEPS];
    if (adv) begin
      result.out_x       <= enc_x;
      result.out_y       <= enc_y;
      result.in_deadzone <= fc.dz;
    end
  end

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.in_deadzone |-> result.out_x == '0 && result.out_y == '0)
    else $error("deadzone beat with nonzero output");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    sample.ready == (!result.valid || result.ready))
    else $error("sample ready not tied to output register");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv_v[DIV_STEPS]) && $stable(e_v))
    else $error("pipeline moved during a stall");
`endif
endmodule
`default_nettype wire

>>> verif/tb.sv
// testbench of the stick radial deadzone unit: random and directed samples against a predictor
`default_nettype none
module tb;
  import srd_pkg::*;

  localparam int LATENCY   = 55;
  localparam int WD_LIMIT  = 20000;
  localparam int N_RANDOM  = 750;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic                    in_dz;
  } stick_res_t;

  // deadzone predictor and queue of pending conditioned results
  class deadzone_board;
    logic [DZ_W-1:0] left_dz;
    logic [DZ_W-1:0] right_dz;
    stick_res_t      pending[$];
    int              errors;

    function new();
      left_dz  = LEFT_DZ_RESET;
      right_dz = RIGHT_DZ_RESET;
      errors   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DZ_W-1:0] val);
      if (idx == REG_LEFT_DZ) left_dz = val;
      else if (idx == REG_RIGHT_DZ) right_dz = val;
    endfunction

    // integer square root, bit by bit
    function logic [63:0] root_of(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic signed [OUT_W-1:0] scale_axis(logic [63:0] mag, logic neg,
                                                 logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = (128'(mag) * 128'(num)) / 128'(den);
      if (neg) begin
        if (q > 128'd65536) q = 128'd65536;
        return -q[OUT_W-1:0];
      end
      if (q > 128'd65535) q = 128'd65535;
      return q[OUT_W-1:0];
    endfunction

    function void note_sample(logic kind, logic signed [RAW_W-1:0] x,
                              logic signed [RAW_W-1:0] y);
      logic [63:0] d, ax, ay, dd, sum, m;
      stick_res_t  e;
      d  = kind ? right_dz : left_dz;
      if (d > DZ_MAX) d = DZ_MAX;
      ax = (x < 0) ? 64'(-32'(x)) * 32767 : 64'(x) * 32768;
      ay = (y < 0) ? 64'(-32'(y)) * 32767 : 64'(y) * 32768;
      dd = d * 32768;
      sum = ax * ax + ay * ay;
      e = '0;
      if (sum < dd * dd) e.in_dz = 1'b1;
      else begin
        m = root_of(sum);
        if (m != 0) begin
          e.out_x = scale_axis(ax, x < 0, m - dd, m * (32767 - d));
          e.out_y = scale_axis(ay, y < 0, m - dd, m * (32767 - d));
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(stick_res_t got);
      stick_res_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d dz=%0b", $time,
                 got.out_x, got.out_y, got.in_dz);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_x !== e.out_x) begin
        $display("%0t out_x expected %0d actual %0d", $time, e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $display("%0t out_y expected %0d actual %0d", $time, e.out_y, got.out_y);
        errors++;
      end
      if (got.in_dz !== e.in_dz) begin
        $display("%0t in_deadzone expected %0b actual %0b", $time, e.in_dz, got.in_dz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DZ_W-1:0]  cfg_data = '0;
  int   idle_cycles = 0;
  bit   stall_free = 1'b0;

  srd_in_if  sample();
  srd_out_if result();

  deadzone_board board = new();

  stick_radial_deadzone_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // accepted beats on both channels; prediction at acceptance time
  always @(posedge clk) begin
    if (!rst) begin
      if (sample.valid && sample.ready)
        board.note_sample(sample.kind, sample.raw_x, sample.raw_y);
      if (result.valid && result.ready)
        board.check_result('{result.out_x, result.out_y, result.in_deadzone});
      if ((sample.valid && sample.ready) || (result.valid && result.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure, with stall-free stretches
  initial begin
    int g;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_free || $urandom_range(0, 9) < 2) begin
        result.ready = 1'b1;
        repeat ($urandom_range(5, 60)) @(negedge clk);
      end else begin
        g = pick_gap();
        result.ready = (g == 0);
        repeat (g == 0 ? 1 : g) @(negedge clk);
        result.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_sample(logic kind, logic signed [RAW_W-1:0] x,
                             logic signed [RAW_W-1:0] y, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      sample.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    sample.valid = 1'b1;
    sample.kind  = kind;
    sample.raw_x = x;
    sample.raw_y = y;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every expected result has left, then let the pipeline drain
  task automatic drain();
    sample.valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DZ_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(idx, val);
  endtask

  // random raw value with the extremes favoured
  function logic signed [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'(signed'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [DZ_W-1:0] dz_set [6];
    sample.valid = 1'b0;
    sample.kind  = 1'b0;
    sample.raw_x = '0;
    sample.raw_y = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset deadzones, axis extremes, zero, just inside and outside
    for (int k = 0; k < 2; k++) begin
      send_sample(1'(k), 16'sd0, 16'sd0, 1'b0);
      send_sample(1'(k), 16'sd32767, 16'sd0, 1'b0);
      send_sample(1'(k), -16'sd32768, 16'sd0, 1'b0);
      send_sample(1'(k), 16'sd32767, 16'sd32767, 1'b0);
      send_sample(1'(k), -16'sd32768, -16'sd32768, 1'b0);
      send_sample(1'(k), 16'sd0, -16'sd32768, 1'b0);
      send_sample(1'(k), 16'sd7849, 16'sd0, 1'b0);
      send_sample(1'(k), 16'sd8689, 16'sd1, 1'b0);
      send_sample(1'(k), -16'sd1, 16'sd1, 1'b0);
    end
    drain();

    // zero deadzone with zero vector; full deadzone with saturating corners
    write_reg(REG_LEFT_DZ, 15'd0);
    write_reg(REG_RIGHT_DZ, 15'd32767);
    send_sample(1'b0, 16'sd0, 16'sd0, 1'b0);
    send_sample(1'b0, 16'sd1, -16'sd1, 1'b0);
    send_sample(1'b1, 16'sd32767, 16'sd32767, 1'b0);
    send_sample(1'b1, -16'sd32768, -16'sd32768, 1'b0);
    send_sample(1'b1, -16'sd32768, 16'sd32767, 1'b0);
    send_sample(1'b1, 16'sd32767, 16'sd0, 1'b0);
    drain();

    dz_set[0] = 15'd0;
    dz_set[1] = 15'd32766;
    dz_set[2] = 15'd32767;
    dz_set[3] = 15'd1;
    dz_set[4] = 15'd16384;
    dz_set[5] = 15'd7849;

    // random phases through several deadzone settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_LEFT_DZ, (p % 2) ? 15'($urandom) : dz_set[p]);
      write_reg(REG_RIGHT_DZ, dz_set[5 - p]);
      stall_free = (p == 2);
      for (int i = 0; i < N_RANDOM / 6; i++)
        send_sample(1'($urandom_range(0, 1)), pick_raw(), pick_raw(), p != 2);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
